// File: rtl/shfm_pkg.sv
// ----------------------------------------------------------------------------
// shfm_pkg
// Shared types, mode and fault codes, and register reset values for the
// sensor health fault manager.
// ----------------------------------------------------------------------------
package shfm_pkg;

    // Operating modes.
    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_WARNING  = 2'd1;
    localparam logic [1:0] MODE_FAULT    = 2'd2;
    localparam logic [1:0] MODE_RECOVERY = 2'd3;

    // Sensor read status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // Fault codes.
    localparam logic [3:0] FLT_NONE        = 4'd0;
    localparam logic [3:0] FLT_HUM_CRC     = 4'd1;
    localparam logic [3:0] FLT_HUM_RANGE   = 4'd2;
    localparam logic [3:0] FLT_PRESS_BUS   = 4'd3;
    localparam logic [3:0] FLT_PRESS_RANGE = 4'd4;
    localparam logic [3:0] FLT_CROSSCHECK  = 4'd5;
    localparam logic [3:0] FLT_TEMP        = 4'd6;
    localparam logic [3:0] FLT_HUMIDITY    = 4'd7;
    localparam logic [3:0] FLT_PRESSURE    = 4'd8;

    // Configuration register indexes.
    localparam logic [2:0] REG_WARN_FAIL_LIMIT      = 3'd0;
    localparam logic [2:0] REG_FAULT_FAIL_LIMIT     = 3'd1;
    localparam logic [2:0] REG_CROSS_CHECK_DELTA    = 3'd2;
    localparam logic [2:0] REG_TEMP_HIGH_LIMIT      = 3'd3;
    localparam logic [2:0] REG_HUMIDITY_HIGH_LIMIT  = 3'd4;
    localparam logic [2:0] REG_PRESSURE_LOW_LIMIT   = 3'd5;
    localparam logic [2:0] REG_REINIT_ATTEMPT_LIMIT = 3'd6;
    localparam logic [2:0] REG_RECOVERY_PERIOD      = 3'd7;

    localparam int CFG_DATA_W = 17;

    typedef struct packed {
        logic [7:0]         warn_fail_limit;
        logic [7:0]         fault_fail_limit;
        logic [14:0]        cross_check_delta;
        logic signed [14:0] temp_high_limit;
        logic [13:0]        humidity_high_limit;
        logic [16:0]        pressure_low_limit;
        logic [7:0]         reinit_attempt_limit;
        logic [6:0]         recovery_period;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        warn_fail_limit:      8'd1,
        fault_fail_limit:     8'd3,
        cross_check_delta:    15'd500,
        temp_high_limit:      15'sd6000,
        humidity_high_limit:  14'd9000,
        pressure_low_limit:   17'd80000,
        reinit_attempt_limit: 8'd3,
        recovery_period:      7'd10
    };

    // One monitoring tick as it sits in the input register.
    typedef struct packed {
        logic [1:0]         hum_sensor_status;
        logic [1:0]         press_sensor_status;
        logic signed [14:0] hum_sensor_temp;
        logic signed [14:0] press_sensor_temp;
        logic [13:0]        humidity;
        logic [16:0]        pressure;
        logic               hum_sensor_init_ok;
        logic               press_sensor_init_ok;
    } item_t;

    // Status reported after each tick.
    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] fault_cause;
        logic [7:0] fail_streak;
        logic [7:0] reinit_count;
    } status_t;

endpackage

// File: rtl/sensor_health_fault_manager_unit.sv
// ----------------------------------------------------------------------------
// sensor_health_fault_manager_unit
// Per-tick sensor health checks and a normal / warning / fault / recovery
// mode machine, reporting mode, fault code and counters for every tick.
//
//   Channel   Signals                                  Direction
//   -------   --------------------------------------   ---------
//   input     in_valid, in_ready, eight item fields    in
//   output    out_valid, out_ready, four status fields out
//   config    cfg_wr_en, cfg_index, cfg_data           in
//
// Each word goes through an input register and then a result register, where
// its result is offered to the output. One word can be accepted every cycle
// while the output is not stalled; the sensor checks and the state update sit
// in one combinational path between the two registers. When the output
// stalls the input register still takes one more word before in_ready drops.
// Reset clears the mode machine, the counters, both valid flags and restores
// the register defaults.
// ----------------------------------------------------------------------------
module sensor_health_fault_manager_unit (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           hum_sensor_status,
    input  logic [1:0]           press_sensor_status,
    input  logic signed [14:0]   hum_sensor_temp,
    input  logic signed [14:0]   press_sensor_temp,
    input  logic [13:0]          humidity,
    input  logic [16:0]          pressure,
    input  logic                 hum_sensor_init_ok,
    input  logic                 press_sensor_init_ok,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           mode,
    output logic [3:0]           fault_cause,
    output logic [7:0]           fail_streak,
    output logic [7:0]           reinit_count,

    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [shfm_pkg::CFG_DATA_W-1:0] cfg_data
);

    shfm_pkg::cfg_t    cfg_reg;
    shfm_pkg::item_t   item_reg;
    shfm_pkg::status_t res_reg;
    shfm_pkg::status_t status_next;

    logic       in_vld_reg;
    logic       out_vld_reg;
    logic       advance;
    logic [3:0] code;

    // A word moves from the input register to the result register whenever
    // the result register is empty or is being read in this cycle.
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= shfm_pkg::CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                shfm_pkg::REG_WARN_FAIL_LIMIT:
                    cfg_reg.warn_fail_limit <= cfg_data[7:0];
                shfm_pkg::REG_FAULT_FAIL_LIMIT:
                    cfg_reg.fault_fail_limit <= cfg_data[7:0];
                shfm_pkg::REG_CROSS_CHECK_DELTA:
                    cfg_reg.cross_check_delta <= cfg_data[14:0];
                shfm_pkg::REG_TEMP_HIGH_LIMIT:
                    cfg_reg.temp_high_limit <= $signed(cfg_data[14:0]);
                shfm_pkg::REG_HUMIDITY_HIGH_LIMIT:
                    cfg_reg.humidity_high_limit <= cfg_data[13:0];
                shfm_pkg::REG_PRESSURE_LOW_LIMIT:
                    cfg_reg.pressure_low_limit <= cfg_data[16:0];
                shfm_pkg::REG_REINIT_ATTEMPT_LIMIT:
                    cfg_reg.reinit_attempt_limit <= cfg_data[7:0];
                shfm_pkg::REG_RECOVERY_PERIOD:
                    cfg_reg.recovery_period <= cfg_data[6:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Valid flags of the two pipeline registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.hum_sensor_status    <= hum_sensor_status;
            item_reg.press_sensor_status  <= press_sensor_status;
            item_reg.hum_sensor_temp      <= hum_sensor_temp;
            item_reg.press_sensor_temp    <= press_sensor_temp;
            item_reg.humidity             <= humidity;
            item_reg.pressure             <= pressure;
            item_reg.hum_sensor_init_ok   <= hum_sensor_init_ok;
            item_reg.press_sensor_init_ok <= press_sensor_init_ok;
        end
        if (advance)
        begin
            res_reg <= status_next;
        end
    end

    shfm_check u_check (
        .item (item_reg),
        .cfg  (cfg_reg),
        .code (code)
    );

    // The mode machine only looks at the check result in normal and warning
    // mode, and only at the init flags in recovery.
    shfm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .code        (code),
        .init_ok     (item_reg.hum_sensor_init_ok && item_reg.press_sensor_init_ok),
        .cfg         (cfg_reg),
        .status_next (status_next)
    );

    assign out_valid    = out_vld_reg;
    assign mode         = res_reg.mode;
    assign fault_cause  = res_reg.fault_cause;
    assign fail_streak  = res_reg.fail_streak;
    assign reinit_count = res_reg.reinit_count;

    // Warning, fault and recovery always carry a fault code.
    a_fault_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mode == shfm_pkg::MODE_FAULT || mode == shfm_pkg::MODE_RECOVERY
                      || mode == shfm_pkg::MODE_WARNING)
        |-> fault_cause != shfm_pkg::FLT_NONE)
        else $error("fault or warning mode reported without a fault code");

    // Fault entry clears the failure counter and recovery never raises it.
    a_fault_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mode == shfm_pkg::MODE_FAULT || mode == shfm_pkg::MODE_RECOVERY)
        |-> fail_streak == 8'd0)
        else $error("failure counter not cleared in fault or recovery");

    // Normal and warning are entered with the re-init counter cleared.
    a_reinit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mode == shfm_pkg::MODE_NORMAL || mode == shfm_pkg::MODE_WARNING)
        |-> reinit_count == 8'd0)
        else $error("re-init counter set outside recovery and fault");

    // A full pipeline with a stalled output must hold off the input.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while both pipeline registers are full");

endmodule

// File: rtl/shfm_check.sv
// ----------------------------------------------------------------------------
// shfm_check
// Priority ordered sensor checks: read status, temperature cross-check,
// then temperature, humidity and pressure thresholds.
// ----------------------------------------------------------------------------
module shfm_check (
    input  shfm_pkg::item_t item,
    input  shfm_pkg::cfg_t  cfg,
    output logic [3:0]      code
);

    logic signed [15:0] diff;
    logic [15:0]        mag;

    always_comb
    begin
        diff = {item.hum_sensor_temp[14], item.hum_sensor_temp}
             - {item.press_sensor_temp[14], item.press_sensor_temp};
        mag  = diff[15] ? 16'(-diff) : 16'(diff);

        if (item.hum_sensor_status == shfm_pkg::STAT_RANGE)
        begin
            code = shfm_pkg::FLT_HUM_RANGE;
        end
        else if (item.hum_sensor_status != shfm_pkg::STAT_OK)
        begin
            code = shfm_pkg::FLT_HUM_CRC;
        end
        else if (item.press_sensor_status == shfm_pkg::STAT_RANGE)
        begin
            code = shfm_pkg::FLT_PRESS_RANGE;
        end
        else if (item.press_sensor_status != shfm_pkg::STAT_OK)
        begin
            code = shfm_pkg::FLT_PRESS_BUS;
        end
        else if (mag > {1'b0, cfg.cross_check_delta})
        begin
            code = shfm_pkg::FLT_CROSSCHECK;
        end
        else if (item.hum_sensor_temp >= cfg.temp_high_limit)
        begin
            code = shfm_pkg::FLT_TEMP;
        end
        else if (item.humidity >= cfg.humidity_high_limit)
        begin
            code = shfm_pkg::FLT_HUMIDITY;
        end
        else if (item.pressure <= cfg.pressure_low_limit)
        begin
            code = shfm_pkg::FLT_PRESSURE;
        end
        else
        begin
            code = shfm_pkg::FLT_NONE;
        end
    end

endmodule

// File: rtl/shfm_ctrl.sv
// ----------------------------------------------------------------------------
// shfm_ctrl
// Mode state machine with the failure, re-init and tick phase counters.
// Produces the status after the update of the current tick.
// ----------------------------------------------------------------------------
module shfm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [3:0]        code,
    input  logic              init_ok,
    input  shfm_pkg::cfg_t    cfg,
    output shfm_pkg::status_t status_next
);

    logic [1:0] mode_reg, mode_next;
    logic [3:0] fault_reg, fault_next;
    logic [7:0] fail_reg, fail_next;
    logic [7:0] reinit_reg, reinit_next;
    logic [6:0] phase_reg, phase_next;

    logic [7:0] phase_inc;
    logic [7:0] fail_inc;
    logic [7:0] reinit_inc;

    always_comb
    begin
        phase_inc  = {1'b0, phase_reg} + 8'd1;
        phase_next = (phase_inc >= {1'b0, cfg.recovery_period}) ? 7'd0 : phase_inc[6:0];
        fail_inc   = (fail_reg == 8'hFF) ? fail_reg : fail_reg + 8'd1;
        reinit_inc = (reinit_reg == 8'hFF) ? reinit_reg : reinit_reg + 8'd1;

        mode_next   = mode_reg;
        fault_next  = fault_reg;
        fail_next   = fail_reg;
        reinit_next = reinit_reg;

        case (mode_reg)
            shfm_pkg::MODE_NORMAL:
            begin
                if (code != shfm_pkg::FLT_NONE)
                begin
                    fail_next = fail_inc;
                    if (fail_inc >= cfg.fault_fail_limit)
                    begin
                        mode_next  = shfm_pkg::MODE_FAULT;
                        fault_next = code;
                        fail_next  = 8'd0;
                    end
                    else if (fail_inc >= cfg.warn_fail_limit)
                    begin
                        mode_next  = shfm_pkg::MODE_WARNING;
                        fault_next = code;
                    end
                end
                else
                begin
                    fail_next  = 8'd0;
                    fault_next = shfm_pkg::FLT_NONE;
                end
            end
            shfm_pkg::MODE_WARNING:
            begin
                if (code != shfm_pkg::FLT_NONE)
                begin
                    fail_next = fail_inc;
                    if (fail_inc >= cfg.fault_fail_limit)
                    begin
                        mode_next  = shfm_pkg::MODE_FAULT;
                        fault_next = code;
                        fail_next  = 8'd0;
                    end
                end
                else
                begin
                    mode_next   = shfm_pkg::MODE_NORMAL;
                    fault_next  = shfm_pkg::FLT_NONE;
                    fail_next   = 8'd0;
                    reinit_next = 8'd0;
                end
            end
            shfm_pkg::MODE_FAULT:
            begin
                if (phase_next == 7'd0)
                begin
                    mode_next   = shfm_pkg::MODE_RECOVERY;
                    reinit_next = 8'd0;
                end
            end
            default:
            begin
                reinit_next = reinit_inc;
                if (init_ok)
                begin
                    mode_next   = shfm_pkg::MODE_NORMAL;
                    fault_next  = shfm_pkg::FLT_NONE;
                    fail_next   = 8'd0;
                    reinit_next = 8'd0;
                end
                else if (reinit_inc >= cfg.reinit_attempt_limit)
                begin
                    mode_next = shfm_pkg::MODE_FAULT;
                    fail_next = 8'd0;
                end
            end
        endcase

        status_next.mode         = mode_next;
        status_next.fault_cause  = fault_next;
        status_next.fail_streak  = fail_next;
        status_next.reinit_count = reinit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= shfm_pkg::MODE_NORMAL;
            fault_reg  <= shfm_pkg::FLT_NONE;
            fail_reg   <= 8'd0;
            reinit_reg <= 8'd0;
            phase_reg  <= 7'd0;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            fault_reg  <= fault_next;
            fail_reg   <= fail_next;
            reinit_reg <= reinit_next;
            phase_reg  <= phase_next;
        end
    end

endmodule
